@@ src/pfe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Palette fade engine package
// Shared widths, command and register codes, monochrome tables and the
// per-color fade function used by the palette walk.
// ----------------------------------------------------------------------------
package pfe_pkg;

	localparam int PALETTE_ENTRIES = 64;
	localparam int IDX_W           = 6;
	localparam int COLOR_W         = 15;
	localparam int CHAN_W          = 5;
	localparam int LEVEL_W         = 3;
	localparam int FADE_STEPS      = 5;
	localparam int TAB_LAST        = 6;
	localparam logic [CHAN_W-1:0] WHITE_BITS = 5'h1F;

	typedef enum logic [2:0] {
		MODE_TICK     = 3'd0,
		MODE_FADE_IN  = 3'd1,
		MODE_FADE_OUT = 3'd2,
		MODE_REAPPLY  = 3'd3,
		MODE_WRITE    = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		CFG_FADE_TO_BLACK   = 2'd0,
		CFG_STEP_FRAME_MASK = 2'd1,
		CFG_COLOR_MODE      = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_WALK  = 3'b010,
		ST_FLUSH = 3'b100
	} seq_state_t;

	typedef logic [7:0] pal_tab_t [0:TAB_LAST];

	localparam pal_tab_t SPR_WHITE_TAB = '{8'h00, 8'h00, 8'h40, 8'h80, 8'h90, 8'hD0, 8'hD0};
	localparam pal_tab_t BKG_WHITE_TAB = '{8'h00, 8'h00, 8'h40, 8'h90, 8'hA4, 8'hE4, 8'hE4};
	localparam pal_tab_t SPR_BLACK_TAB = '{8'hFF, 8'hFF, 8'hF8, 8'hE4, 8'hD4, 8'hD0, 8'hD0};
	localparam pal_tab_t BKG_BLACK_TAB = '{8'hFF, 8'hFF, 8'hFE, 8'hE9, 8'hE5, 8'hE4, 8'hE4};

	// Fades one RGB555 color to the given level.
	function automatic logic [COLOR_W-1:0] fade_color(
		input logic [COLOR_W-1:0] col,
		input logic [LEVEL_W-1:0] lv,
		input logic               to_black
	);
		logic [LEVEL_W-1:0] sh;
		logic [CHAN_W-1:0]  w;
		logic [COLOR_W-1:0] res;
		sh = LEVEL_W'(FADE_STEPS) - lv;
		w  = WHITE_BITS >> lv;
		if (lv >= LEVEL_W'(FADE_STEPS)) begin
			res = col;
		end else if (to_black) begin
			res = {col[14:10] >> sh, col[9:5] >> sh, col[4:0] >> sh};
		end else begin
			res = col | {w, w, w};
		end
		return res;
	endfunction

	// Monochrome table position; levels past the table end use its last entry.
	function automatic logic [2:0] tab_pos(input logic [LEVEL_W-1:0] lv);
		return (lv > 3'(TAB_LAST)) ? 3'(TAB_LAST) : lv;
	endfunction

endpackage
`default_nettype wire

@@ src/palette_fade_engine_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Palette fade engine
// Steps a 64-entry RGB555 palette toward white or black, or drives a
// monochrome palette register pair, one fade level per command.
// ----------------------------------------------------------------------------
// Usage:
// A command (mode, color_index, color_value) transfers at a clock edge where
// start is high and busy is low. Ticks, fade starts and reapply commands
// that apply a level emit results; color writes, off-step ticks and idle
// ticks emit none.
// Each result is shown for one cycle with result_strobe high; last marks the
// final result of a command. The receiver cannot stall the block.
// In color mode one shared fade unit walks the palette memory one entry per
// cycle: each entry passes through the memory read register and then the
// result register, and results come out one per cycle. Busy stays high
// through the walk state and then the flush state while the memory read and
// output registers drain, and the final result is shown in the first cycle
// with busy low. In monochrome mode the single result is shown right after
// the edge that takes the command and busy never rises.
// Configuration writes take effect at once; the user must make them while
// idle, unenforced by the block. Reset clears level, frame counter, flags,
// sets registers to defaults, marks all palette entries black till written.
// ----------------------------------------------------------------------------
module palette_fade_engine_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [2:0]                    mode,
	input  wire logic [pfe_pkg::IDX_W-1:0]     color_index,
	input  wire logic [pfe_pkg::COLOR_W-1:0]   color_value,
	input  wire logic                          cfg_we,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [7:0]                    cfg_data,
	output logic                               result_strobe,
	output logic                               is_color_entry,
	output logic [pfe_pkg::IDX_W-1:0]          out_index,
	output logic [pfe_pkg::COLOR_W-1:0]        faded_color,
	output logic [7:0]                         sprite_palette_reg,
	output logic [7:0]                         background_palette_reg,
	output logic [pfe_pkg::LEVEL_W-1:0]        fade_level,
	output logic                               fade_active,
	output logic                               last
);

	pfe_pkg::seq_state_t state_q, state_d;

	logic                           fade_to_black_q;
	logic [7:0]                     step_frame_mask_q;
	logic                           color_mode_q;

	logic [pfe_pkg::LEVEL_W-1:0]    level_q, level_d, level_step;
	logic [7:0]                     frame_q, frame_d;
	logic                           running_q, running_d;
	logic                           fading_in_q, fading_in_d;

	logic                           accept;
	logic                           apply_go;
	logic                           wr_go;

	logic [pfe_pkg::COLOR_W-1:0]    pal_mem [0:pfe_pkg::PALETTE_ENTRIES-1];
	logic [pfe_pkg::PALETTE_ENTRIES-1:0] pal_vld_q;

	logic [pfe_pkg::IDX_W-1:0]      cnt_q;
	logic                           rd_pend_s1;
	logic [pfe_pkg::IDX_W-1:0]      rd_idx_s1;
	logic                           rd_last_s1;
	logic [pfe_pkg::COLOR_W-1:0]    rd_data_s1;
	logic                           rd_vld_s1;
	logic [pfe_pkg::COLOR_W-1:0]    src_color;

	assign accept = start && !busy;
	assign busy   = (state_q != pfe_pkg::ST_IDLE);

	// Command decode and fade state update.
	always_comb begin
		level_d     = level_q;
		frame_d     = frame_q;
		running_d   = running_q;
		fading_in_d = fading_in_q;
		apply_go    = 1'b0;
		wr_go       = 1'b0;
		level_step  = level_q;
		if (fading_in_q) begin
			if (level_q < pfe_pkg::LEVEL_W'(pfe_pkg::FADE_STEPS)) begin
				level_step = level_q + 1'b1;
			end
		end else if (level_q != '0) begin
			level_step = level_q - 1'b1;
		end
		if (accept) begin
			unique case (mode)
				pfe_pkg::MODE_TICK: begin
					if (running_q) begin
						frame_d = frame_q + 8'd1;
						if ((frame_q & step_frame_mask_q) == 8'd0) begin
							level_d  = level_step;
							apply_go = 1'b1;
							if (fading_in_q) begin
								if (level_step >= pfe_pkg::LEVEL_W'(pfe_pkg::FADE_STEPS)) begin
									running_d = 1'b0;
								end
							end else if (level_step == '0) begin
								running_d = 1'b0;
							end
						end
					end
				end
				pfe_pkg::MODE_FADE_IN: begin
					frame_d     = 8'd0;
					fading_in_d = 1'b1;
					running_d   = 1'b1;
					level_d     = '0;
					apply_go    = 1'b1;
				end
				pfe_pkg::MODE_FADE_OUT: begin
					frame_d     = 8'd0;
					fading_in_d = 1'b0;
					running_d   = 1'b1;
					level_d     = pfe_pkg::LEVEL_W'(pfe_pkg::FADE_STEPS);
					apply_go    = 1'b1;
				end
				pfe_pkg::MODE_REAPPLY: begin
					apply_go = 1'b1;
				end
				pfe_pkg::MODE_WRITE: begin
					wr_go = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pfe_pkg::ST_IDLE: begin
				if (apply_go && color_mode_q) begin
					state_d = pfe_pkg::ST_WALK;
				end
			end
			pfe_pkg::ST_WALK: begin
				if (cnt_q == pfe_pkg::IDX_W'(pfe_pkg::PALETTE_ENTRIES - 1)) begin
					state_d = pfe_pkg::ST_FLUSH;
				end
			end
			pfe_pkg::ST_FLUSH: begin
				state_d = pfe_pkg::ST_IDLE;
			end
			default: begin
				state_d = pfe_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= pfe_pkg::ST_IDLE;
			fade_to_black_q   <= 1'b0;
			step_frame_mask_q <= 8'd1;
			color_mode_q      <= 1'b1;
			level_q           <= '0;
			frame_q           <= 8'd0;
			running_q         <= 1'b0;
			fading_in_q       <= 1'b0;
			cnt_q             <= '0;
			rd_pend_s1        <= 1'b0;
			pal_vld_q         <= '0;
			result_strobe     <= 1'b0;
		end else begin
			state_q     <= state_d;
			level_q     <= level_d;
			frame_q     <= frame_d;
			running_q   <= running_d;
			fading_in_q <= fading_in_d;
			if (cfg_we) begin
				unique case (cfg_index)
					pfe_pkg::CFG_FADE_TO_BLACK:   fade_to_black_q   <= cfg_data[0];
					pfe_pkg::CFG_STEP_FRAME_MASK: step_frame_mask_q <= cfg_data;
					pfe_pkg::CFG_COLOR_MODE:      color_mode_q      <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (state_q == pfe_pkg::ST_WALK) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			rd_pend_s1 <= (state_q == pfe_pkg::ST_WALK);
			if (wr_go) begin
				pal_vld_q[color_index] <= 1'b1;
			end
			result_strobe <= rd_pend_s1 || (apply_go && !color_mode_q);
		end
	end

	// Palette memory: one write port for commands, one read port for the walk.
	always_ff @(posedge clk) begin
		if (wr_go) begin
			pal_mem[color_index] <= color_value;
		end
		rd_data_s1 <= pal_mem[cnt_q];
		rd_vld_s1  <= pal_vld_q[cnt_q];
		rd_idx_s1  <= cnt_q;
		rd_last_s1 <= (cnt_q == pfe_pkg::IDX_W'(pfe_pkg::PALETTE_ENTRIES - 1));
	end

	// Entries never written since reset read as black.
	assign src_color = rd_vld_s1 ? rd_data_s1 : '0;

	// Result register: the shared fade unit feeds it during a walk, the
	// monochrome tables feed it otherwise.
	always_ff @(posedge clk) begin
		if (rd_pend_s1) begin
			is_color_entry         <= 1'b1;
			out_index              <= rd_idx_s1;
			faded_color            <= pfe_pkg::fade_color(src_color, level_q, fade_to_black_q);
			sprite_palette_reg     <= 8'd0;
			background_palette_reg <= 8'd0;
			fade_level             <= level_q;
			fade_active            <= running_q;
			last                   <= rd_last_s1;
		end else begin
			is_color_entry         <= 1'b0;
			out_index              <= '0;
			faded_color            <= '0;
			sprite_palette_reg     <= fade_to_black_q ?
				pfe_pkg::SPR_BLACK_TAB[pfe_pkg::tab_pos(level_d)] :
				pfe_pkg::SPR_WHITE_TAB[pfe_pkg::tab_pos(level_d)];
			background_palette_reg <= fade_to_black_q ?
				pfe_pkg::BKG_BLACK_TAB[pfe_pkg::tab_pos(level_d)] :
				pfe_pkg::BKG_WHITE_TAB[pfe_pkg::tab_pos(level_d)];
			fade_level             <= level_d;
			fade_active            <= running_d;
			last                   <= 1'b1;
		end
	end

endmodule
`default_nettype wire
